[design/elhm_pkg.sv]
// Shared types, constants and helpers of the call latency histogram monitor.
package elhm_pkg;

    localparam int THREAD_SLOTS_DEF    = 8192;
    localparam int CALL_SLOTS_DEF      = 1024;
    localparam int HIST_BINS_DEF       = 32;
    localparam int DATA_W              = 64;
    localparam int NS_PER_US           = 1000;
    // wide enough for 1000 << 63
    localparam int THR_W               = 74;
    localparam int RECIP_SHIFT         = 26;
    localparam int SLOT_RAW_W          = 13;

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        STAT_FILTERED = 3'd0,
        STAT_STARTED  = 3'd1,
        STAT_NO_START = 3'd2,
        STAT_UPDATED  = 3'd3,
        STAT_READ     = 3'd4,
        STAT_RANGE    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_LOOK,
        ST_CALC,
        ST_BKT,
        ST_HIST,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [31:0]           process_id;
        logic [SLOT_RAW_W-1:0] thread_slot;
        logic [63:0]           timestamp_ns;
        logic [11:0]           call_id;
        logic [4:0]            bucket_index;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  out_call_id;
        logic [63:0] measured_lat;
        logic [4:0]  bucket;
        logic [63:0] event_count;
        logic [63:0] total_latency;
        logic [63:0] max_latency;
        logic [63:0] bucket_count;
    } t_result;

    // lowest latency in ns that falls into bucket b
    function automatic logic [THR_W-1:0] elhm_threshold(input int b);
        logic [THR_W-1:0] thr;
        thr = THR_W'(NS_PER_US) << b;
        return thr;
    endfunction

endpackage

[design/elhm_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
module elhm_ram #(
    parameter int WIDTH = elhm_pkg::DATA_W,
    parameter int DEPTH = elhm_pkg::CALL_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/elhm_slot.sv]
// Thread slot reduction modulo the table depth by reciprocal multiplication.
module elhm_slot #(
    parameter int THREAD_SLOTS = elhm_pkg::THREAD_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [elhm_pkg::SLOT_RAW_W-1:0] i_raw,
    output logic [$clog2(THREAD_SLOTS)-1:0] o_slot
);

    import elhm_pkg::*;

    localparam int SLOT_W  = $clog2(THREAD_SLOTS);
    localparam int RCP_W   = RECIP_SHIFT + 1;
    localparam int PROD_W  = SLOT_RAW_W + RCP_W;
    localparam int REM_W   = SLOT_RAW_W + 18;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << RECIP_SHIFT)
        + 64'(THREAD_SLOTS) - 64'd1) / 64'(THREAD_SLOTS));

    logic [SLOT_RAW_W-1:0] r_q;
    logic [PROD_W-1:0]     prod;
    logic [REM_W-1:0]      rem;

    // quotient is exact for every 13-bit value, so no correction step
    assign prod = PROD_W'(i_raw) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= SLOT_RAW_W'(prod >> RECIP_SHIFT);
        end
    end

    assign rem    = REM_W'(i_raw) - REM_W'(r_q) * REM_W'(THREAD_SLOTS);
    assign o_slot = rem[SLOT_W-1:0];

endmodule

[design/elhm_bucket.sv]
// Log2 microsecond bucket of a latency: registered threshold compare, then encode.
module elhm_bucket #(
    parameter int HIST_BINS = elhm_pkg::HIST_BINS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [elhm_pkg::DATA_W-1:0]  i_lat,
    output logic [$clog2(HIST_BINS)-1:0] o_bucket
);

    import elhm_pkg::*;

    localparam int BKT_W = $clog2(HIST_BINS);

    logic [HIST_BINS-1:0] r_ge;
    logic [HIST_BINS-1:0] n_ge;

    // thermometer: bit b set when the latency reaches bucket b
    always_comb begin
        n_ge = '0;
        for (int b = 1; b < HIST_BINS; b++) begin
            n_ge[b] = THR_W'(i_lat) >= elhm_threshold(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ge <= n_ge;
        end
    end

    // top bucket caps itself: no threshold beyond it
    always_comb begin
        o_bucket = '0;
        for (int b = 1; b < HIST_BINS; b++) begin
            if (r_ge[b]) begin
                o_bucket = BKT_W'(b);
            end
        end
    end

endmodule

[design/event_latency_histogram_monitor_unit.sv]
// Top level of the call latency histogram monitor: control and statistics tables.
//
// Each item raises a result strobe of one cycle that the receiver must take
// as it comes. After reset the block sweeps its start, statistics and
// histogram memories to zero, one entry per cycle, over the larger of
// THREAD_SLOTS, CALL_SLOTS and CALL_SLOTS * 2**ceil(log2(HIST_BINS))
// addresses (32768 with the default sizes) while busy is high; the filter may
// be written during that time. Items are then handled one at a time: an
// enter, a filtered item, an undefined opcode or a read of an out-of-range
// id ends in the lookup state, any other read or an exit without a start
// in the calc state, and an exit that updates statistics goes on through
// the bucket, histogram and update states. The steps come from the registered
// reads of the memories: the start entry is read before its call id is
// known, the latency must be bucketed before the histogram entry can be
// read, and the statistics are written back in one read-modify-write.
// The result appears in the cycle after the last busy cycle.
module event_latency_histogram_monitor_unit #(
    parameter int THREAD_SLOTS = elhm_pkg::THREAD_SLOTS_DEF,
    parameter int CALL_SLOTS   = elhm_pkg::CALL_SLOTS_DEF,
    parameter int HIST_BINS    = elhm_pkg::HIST_BINS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  elhm_pkg::t_item   i_item,
    output logic              o_strobe,
    output elhm_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data
);

    import elhm_pkg::*;

    localparam int SLOT_W     = $clog2(THREAD_SLOTS);
    localparam int ID_W       = $clog2(CALL_SLOTS);
    localparam int BKT_W      = $clog2(HIST_BINS);
    localparam int HA_W       = ID_W + BKT_W;
    localparam int HIST_DEPTH = CALL_SLOTS * (1 << BKT_W);
    localparam int START_W    = 1 + ID_W + DATA_W;
    localparam int STAT_W     = 3 * DATA_W;
    localparam int CLR_A      = (THREAD_SLOTS > CALL_SLOTS) ? THREAD_SLOTS : CALL_SLOTS;
    localparam int CLR_LEN    = (CLR_A > HIST_DEPTH) ? CLR_A : HIST_DEPTH;
    localparam int CLR_W      = $clog2(CLR_LEN);

    t_state              r_state, n_state;
    logic [CLR_W-1:0]    r_clr;
    logic [31:0]         r_filter;
    t_item               r_item;
    logic                r_pass;
    logic [DATA_W-1:0]   r_lat;
    logic [ID_W-1:0]     r_id;
    logic [BKT_W-1:0]    r_bkt;
    t_result             r_result, n_result;
    logic                r_strobe;

    logic                accept;
    logic                cid_ok;
    logic                bkt_ok;
    logic [ID_W-1:0]     cid_idx;
    logic [BKT_W-1:0]    bidx_idx;
    logic [SLOT_W-1:0]   slot;
    logic [BKT_W-1:0]    bkt_enc;
    logic                q_load, calc_load, bkt_load, hist_load, res_load;

    logic                st_we, st_re;
    logic [SLOT_W-1:0]   st_waddr;
    logic [START_W-1:0]  st_wdata, st_q;
    logic                st_valid;
    logic [ID_W-1:0]     st_call;
    logic [DATA_W-1:0]   st_time;

    logic                ss_we, ss_re;
    logic [ID_W-1:0]     ss_waddr, ss_raddr;
    logic [STAT_W-1:0]   ss_wdata, ss_q;
    logic [DATA_W-1:0]   cnt_q, sum_q, peak_q;

    logic                hs_we, hs_re;
    logic [HA_W-1:0]     hs_waddr, hs_raddr;
    logic [DATA_W-1:0]   hs_wdata, hs_q;

    logic                clr_last, clr_start, clr_stat, clr_hist;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign cid_ok   = 13'(r_item.call_id) < 13'(CALL_SLOTS);
    assign bkt_ok   = 7'(r_item.bucket_index) < 7'(HIST_BINS);
    assign cid_idx  = r_item.call_id[ID_W-1:0];
    assign bidx_idx = BKT_W'(r_item.bucket_index);

    assign st_valid = st_q[START_W-1];
    assign st_call  = st_q[START_W-2:DATA_W];
    assign st_time  = st_q[DATA_W-1:0];
    assign cnt_q    = ss_q[STAT_W-1:2*DATA_W];
    assign sum_q    = ss_q[2*DATA_W-1:DATA_W];
    assign peak_q   = ss_q[DATA_W-1:0];

    assign clr_last  = (r_clr == CLR_W'(CLR_LEN - 1));
    assign clr_start = {1'b0, r_clr} < (CLR_W + 1)'(THREAD_SLOTS);
    assign clr_stat  = {1'b0, r_clr} < (CLR_W + 1)'(CALL_SLOTS);
    assign clr_hist  = {1'b0, r_clr} < (CLR_W + 1)'(HIST_DEPTH);

    elhm_slot #(
        .THREAD_SLOTS(THREAD_SLOTS)
    ) u_slot (
        .i_clk (i_clk),
        .i_load(q_load),
        .i_raw (r_item.thread_slot),
        .o_slot(slot)
    );

    elhm_bucket #(
        .HIST_BINS(HIST_BINS)
    ) u_bucket (
        .i_clk   (i_clk),
        .i_load  (bkt_load),
        .i_lat   (r_lat),
        .o_bucket(bkt_enc)
    );

    elhm_ram #(
        .WIDTH(START_W),
        .DEPTH(THREAD_SLOTS)
    ) u_start_ram (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_re   (st_re),
        .i_raddr(slot),
        .o_rdata(st_q)
    );

    elhm_ram #(
        .WIDTH(STAT_W),
        .DEPTH(CALL_SLOTS)
    ) u_stat_ram (
        .i_clk  (i_clk),
        .i_we   (ss_we),
        .i_waddr(ss_waddr),
        .i_wdata(ss_wdata),
        .i_re   (ss_re),
        .i_raddr(ss_raddr),
        .o_rdata(ss_q)
    );

    elhm_ram #(
        .WIDTH(DATA_W),
        .DEPTH(HIST_DEPTH)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (hs_we),
        .i_waddr(hs_waddr),
        .i_wdata(hs_wdata),
        .i_re   (hs_re),
        .i_raddr(hs_raddr),
        .o_rdata(hs_q)
    );

    always_comb begin : next_state
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SLOT;
                end
            end
            ST_SLOT: n_state = ST_LOOK;
            ST_LOOK: begin
                if ((r_item.opcode == OP_EXIT && r_pass)
                        || (r_item.opcode == OP_READ && cid_ok)) begin
                    n_state = ST_CALC;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CALC: begin
                if (r_item.opcode == OP_EXIT && st_valid) begin
                    n_state = ST_BKT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_BKT:  n_state = ST_HIST;
            ST_HIST: n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin : outputs
        st_we     = 1'b0;
        st_re     = 1'b0;
        st_waddr  = slot;
        st_wdata  = '0;
        ss_we     = 1'b0;
        ss_re     = 1'b0;
        ss_waddr  = r_id;
        ss_raddr  = cid_idx;
        ss_wdata  = '0;
        hs_we     = 1'b0;
        hs_re     = 1'b0;
        hs_waddr  = {r_id, r_bkt};
        hs_raddr  = {cid_idx, bidx_idx};
        hs_wdata  = '0;
        q_load    = 1'b0;
        calc_load = 1'b0;
        bkt_load  = 1'b0;
        hist_load = 1'b0;
        res_load  = 1'b0;
        n_result  = '0;
        case (r_state)
            ST_CLEAR: begin
                st_we    = clr_start;
                st_waddr = r_clr[SLOT_W-1:0];
                ss_we    = clr_stat;
                ss_waddr = r_clr[ID_W-1:0];
                hs_we    = clr_hist;
                hs_waddr = r_clr[HA_W-1:0];
            end
            ST_SLOT: q_load = 1'b1;
            ST_LOOK: begin
                case (r_item.opcode)
                    OP_ENTER: begin
                        res_load = 1'b1;
                        if (!r_pass) begin
                            n_result.status = STAT_FILTERED;
                        end else if (!cid_ok) begin
                            // drop any live start on this slot
                            st_we           = 1'b1;
                            n_result.status = STAT_RANGE;
                        end else begin
                            st_we                = 1'b1;
                            st_wdata             = {1'b1, cid_idx, r_item.timestamp_ns};
                            n_result.status      = STAT_STARTED;
                            n_result.out_call_id = 10'(r_item.call_id);
                        end
                    end
                    OP_EXIT: begin
                        if (!r_pass) begin
                            res_load        = 1'b1;
                            n_result.status = STAT_FILTERED;
                        end else begin
                            st_re = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (!cid_ok) begin
                            res_load        = 1'b1;
                            n_result.status = STAT_RANGE;
                        end else begin
                            ss_re = 1'b1;
                            hs_re = 1'b1;
                        end
                    end
                    default: begin
                        res_load        = 1'b1;
                        n_result.status = STAT_FILTERED;
                    end
                endcase
            end
            ST_CALC: begin
                if (r_item.opcode == OP_READ) begin
                    res_load               = 1'b1;
                    n_result.status        = STAT_READ;
                    n_result.out_call_id   = 10'(r_item.call_id);
                    n_result.bucket        = r_item.bucket_index;
                    n_result.event_count   = cnt_q;
                    n_result.total_latency = sum_q;
                    n_result.max_latency   = peak_q;
                    n_result.bucket_count  = bkt_ok ? hs_q : '0;
                end else if (!st_valid) begin
                    res_load        = 1'b1;
                    n_result.status = STAT_NO_START;
                end else begin
                    // free the slot and fetch the call's statistics
                    calc_load = 1'b1;
                    st_we     = 1'b1;
                    ss_re     = 1'b1;
                    ss_raddr  = st_call;
                end
            end
            ST_BKT:  bkt_load = 1'b1;
            ST_HIST: begin
                hist_load = 1'b1;
                hs_re     = 1'b1;
                hs_raddr  = {r_id, bkt_enc};
            end
            ST_UPD: begin
                ss_we    = 1'b1;
                ss_wdata = {cnt_q + 64'd1, sum_q + r_lat, (r_lat > peak_q) ? r_lat : peak_q};
                hs_we    = 1'b1;
                hs_wdata = hs_q + 64'd1;
                res_load = 1'b1;
                n_result.status        = STAT_UPDATED;
                n_result.out_call_id   = 10'(r_id);
                n_result.measured_lat  = r_lat;
                n_result.bucket        = 5'(r_bkt);
                n_result.event_count   = cnt_q + 64'd1;
                n_result.total_latency = sum_q + r_lat;
                n_result.max_latency   = (r_lat > peak_q) ? r_lat : peak_q;
                n_result.bucket_count  = hs_q + 64'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_filter <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= res_load;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (i_cfg_we) begin
                r_filter <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_pass <= (r_filter == 32'd0) || (i_item.process_id == r_filter);
        end
        if (calc_load) begin
            r_lat <= r_item.timestamp_ns - st_time;
            r_id  <= st_call;
        end
        if (hist_load) begin
            r_bkt <= bkt_enc;
        end
        if (res_load) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[dv/latency_stats_checker.sv]
// Checker for the latency histogram monitor: predicts each result and compares it.
`timescale 1ns / 100ps
module latency_stats_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  elhm_pkg::t_item   i_item,
    input  logic              i_strobe,
    input  elhm_pkg::t_result i_result,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data,
    output int                o_pending,
    output int                o_fail_count
);
    import elhm_pkg::*;

    // start entries per thread slot
    bit          slot_live [THREAD_SLOTS_DEF];
    logic [63:0] slot_ts   [THREAD_SLOTS_DEF];
    logic [9:0]  slot_call [THREAD_SLOTS_DEF];
    // statistics per call id
    logic [63:0] n_calls   [CALL_SLOTS_DEF];
    logic [63:0] lat_total [CALL_SLOTS_DEF];
    logic [63:0] lat_peak  [CALL_SLOTS_DEF];
    logic [63:0] hist_cnt  [CALL_SLOTS_DEF][HIST_BINS_DEF];
    logic [31:0] pid_filter = '0;
    t_result     result_q[$];
    int          fail_cnt = 0;

    function automatic logic [4:0] log2_bucket(input logic [63:0] lat);
        logic [63:0] us;
        int          b;
        us = lat / 64'd1000;
        b  = 0;
        while (us > 64'd1 && b < HIST_BINS_DEF - 1) begin
            us = us >> 1;
            b++;
        end
        return b[4:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, wanted 0x%0h", name, got, want));
    endtask

    task automatic predict_result(input t_item it, output t_result r);
        int          slot;
        int          id;
        logic [63:0] lat;
        logic [4:0]  b;
        logic        traced;
        r      = '0;
        slot   = int'(it.thread_slot) % THREAD_SLOTS_DEF;
        traced = (pid_filter == '0) || (it.process_id == pid_filter);
        case (it.opcode)
            OP_ENTER: begin
                if (!traced) begin
                    r.status = STAT_FILTERED;
                end else if (int'(it.call_id) >= CALL_SLOTS_DEF) begin
                    // a bad id still frees the slot
                    slot_live[slot] = 1'b0;
                    r.status = STAT_RANGE;
                end else begin
                    slot_live[slot] = 1'b1;
                    slot_ts[slot]   = it.timestamp_ns;
                    slot_call[slot] = it.call_id[9:0];
                    r.status        = STAT_STARTED;
                    r.out_call_id   = it.call_id[9:0];
                end
            end
            OP_EXIT: begin
                if (!traced) begin
                    r.status = STAT_FILTERED;
                end else if (!slot_live[slot]) begin
                    r.status = STAT_NO_START;
                end else begin
                    lat             = it.timestamp_ns - slot_ts[slot];
                    id              = int'(slot_call[slot]);
                    slot_live[slot] = 1'b0;
                    n_calls[id]     = n_calls[id] + 64'd1;
                    lat_total[id]   = lat_total[id] + lat;
                    if (lat > lat_peak[id])
                        lat_peak[id] = lat;
                    b               = log2_bucket(lat);
                    hist_cnt[id][b] = hist_cnt[id][b] + 64'd1;
                    r.status        = STAT_UPDATED;
                    r.out_call_id   = id[9:0];
                    r.measured_lat  = lat;
                    r.bucket        = b;
                    r.event_count   = n_calls[id];
                    r.total_latency = lat_total[id];
                    r.max_latency   = lat_peak[id];
                    r.bucket_count  = hist_cnt[id][b];
                end
            end
            OP_READ: begin
                if (int'(it.call_id) >= CALL_SLOTS_DEF) begin
                    r.status = STAT_RANGE;
                end else begin
                    id              = int'(it.call_id);
                    r.status        = STAT_READ;
                    r.out_call_id   = id[9:0];
                    r.bucket        = it.bucket_index;
                    r.event_count   = n_calls[id];
                    r.total_latency = lat_total[id];
                    r.max_latency   = lat_peak[id];
                    if (int'(it.bucket_index) < HIST_BINS_DEF)
                        r.bucket_count = hist_cnt[id][it.bucket_index];
                end
            end
            default: r.status = STAT_FILTERED;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            pid_filter = '0;
            result_q.delete();
            for (int s = 0; s < THREAD_SLOTS_DEF; s++)
                slot_live[s] = 1'b0;
            for (int c = 0; c < CALL_SLOTS_DEF; c++) begin
                n_calls[c]   = '0;
                lat_total[c] = '0;
                lat_peak[c]  = '0;
                for (int k = 0; k < HIST_BINS_DEF; k++)
                    hist_cnt[c][k] = '0;
            end
        end else begin
            if (i_start && !i_busy) begin
                predict_result(i_item, want);
                result_q.push_back(want);
            end
            if (i_strobe) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result strobe with no item outstanding");
                end else begin
                    want = result_q.pop_front();
                    check_field("status", 64'(i_result.status), 64'(want.status));
                    check_field("out_call_id", 64'(i_result.out_call_id),
                                64'(want.out_call_id));
                    check_field("measured_lat", i_result.measured_lat,
                                want.measured_lat);
                    check_field("bucket", 64'(i_result.bucket), 64'(want.bucket));
                    check_field("event_count", i_result.event_count, want.event_count);
                    check_field("total_latency", i_result.total_latency,
                                want.total_latency);
                    check_field("max_latency", i_result.max_latency, want.max_latency);
                    check_field("bucket_count", i_result.bucket_count,
                                want.bucket_count);
                end
            end
            // a write lands after any item taken on the same edge
            if (i_cfg_we)
                pid_filter = i_cfg_data;
        end
        o_pending    <= result_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

[dv/tb_top.sv]
// Testbench top for the latency histogram monitor: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
    import elhm_pkg::*;

    localparam int          WATCHDOG_LIMIT = 200000;
    localparam int          POOL           = 16;
    localparam int          PHASES         = 5;
    localparam int          PHASE_ITEMS    = 145;
    localparam logic [1:0]  OP_UNDEFINED   = 2'd3;
    localparam logic [31:0] FILTER_ALL     = 32'h0;
    localparam logic [31:0] FILTER_TOP     = 32'hFFFF_FFFF;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_item       i_item     = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_we   = 1'b0;
    logic [31:0] i_cfg_data = '0;
    int          pending;
    int          fail_count;

    int          max_gap = 10;
    logic [31:0] cur_filter = '0;
    logic [12:0] pool_slot [POOL];
    logic [63:0] pool_ts   [POOL];
    logic [31:0] phase_filter [PHASES];

    always #5 i_clk = ~i_clk;

    event_latency_histogram_monitor_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    latency_stats_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic t_item make_item(input logic [1:0] op, input logic [31:0] pid,
                                        input logic [12:0] slot, input logic [63:0] ts,
                                        input logic [11:0] cid, input logic [4:0] bidx);
        t_item it;
        it.opcode       = op;
        it.process_id   = pid;
        it.thread_slot  = slot;
        it.timestamp_ns = ts;
        it.call_id      = cid;
        it.bucket_index = bidx;
        return it;
    endfunction

    // latency with a random width, so every bucket gets hit
    function automatic logic [63:0] random_latency();
        int          sh;
        logic [63:0] mask;
        sh   = $urandom_range(1, 64);
        mask = (sh == 64) ? '1 : ((64'd1 << sh) - 64'd1);
        return {$urandom, $urandom} & mask;
    endfunction

    function automatic logic [31:0] traced_pid();
        if (cur_filter != FILTER_ALL && $urandom_range(0, 99) < 85)
            return cur_filter;
        return $urandom;
    endfunction

    // called on a clock edge; returns on the edge that takes the transfer
    task automatic issue(input t_item it);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_filter(input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        cur_filter  = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_item();
        int          k;
        int          roll;
        logic [11:0] cid;
        t_item       it;
        roll = $urandom_range(0, 99);
        k    = $urandom_range(0, POOL - 1);
        cid  = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 1023))
                                           : 12'($urandom_range(0, 15));
        if (roll < 35) begin
            pool_ts[k] = {$urandom, $urandom};
            it = make_item(OP_ENTER, traced_pid(), pool_slot[k], pool_ts[k], cid,
                           5'($urandom));
        end else if (roll < 70) begin
            it = make_item(OP_EXIT, traced_pid(), pool_slot[k],
                           pool_ts[k] + random_latency(), 12'($urandom), 5'($urandom));
        end else if (roll < 85) begin
            if ($urandom_range(0, 7) == 0)
                cid = 12'($urandom);
            it = make_item(OP_READ, $urandom, 13'($urandom), {$urandom, $urandom},
                           cid, 5'($urandom_range(0, 31)));
        end else if (roll < 90) begin
            it = make_item(OP_ENTER, traced_pid(), pool_slot[k], {$urandom, $urandom},
                           12'($urandom_range(1024, 4095)), 5'($urandom));
        end else begin
            it = make_item(2'($urandom), $urandom, 13'($urandom), {$urandom, $urandom},
                           12'($urandom), 5'($urandom));
        end
        issue(it);
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        pool_slot[0] = 13'd0;
        pool_slot[1] = 13'h1FFF;
        for (int i = 2; i < POOL; i++)
            pool_slot[i] = 13'($urandom);
        for (int i = 0; i < POOL; i++)
            pool_ts[i] = '0;
        phase_filter = '{FILTER_ALL, FILTER_TOP, 32'h1, $urandom | 32'h1, FILTER_ALL};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the filter may be written while the memories are swept
        write_filter(FILTER_ALL);

        issue(make_item(OP_READ, $urandom, 13'd0, '0, 12'd0, 5'd0));
        issue(make_item(OP_EXIT, $urandom, 13'd5, 64'd10, 12'd0, 5'd0));
        issue(make_item(OP_ENTER, $urandom, 13'd0, 64'd0, 12'd0, 5'd0));
        issue(make_item(OP_EXIT, $urandom, 13'd0, 64'd999, 12'd0, 5'd0));
        // largest latency: wraps round and caps at the top bucket
        issue(make_item(OP_ENTER, FILTER_TOP, 13'h1FFF, '1, 12'd1023, 5'd31));
        issue(make_item(OP_EXIT, FILTER_TOP, 13'h1FFF, 64'hFFFF_FFFF_FFFF_FFFE,
                        12'd0, 5'd31));
        issue(make_item(OP_ENTER, $urandom, 13'd1, 64'd50, 12'hFFF, 5'd0));
        issue(make_item(OP_EXIT, $urandom, 13'd1, 64'd60, 12'd0, 5'd0));
        issue(make_item(OP_ENTER, $urandom, 13'd2, 64'd100, 12'd5, 5'd0));
        issue(make_item(OP_ENTER, $urandom, 13'd2, 64'd200, 12'd6, 5'd0));
        issue(make_item(OP_EXIT, $urandom, 13'd2, 64'd2200, 12'd0, 5'd0));
        issue(make_item(OP_ENTER, $urandom, 13'd3, 64'd0, 12'd6, 5'd0));
        issue(make_item(OP_EXIT, $urandom, 13'd3, 64'd1999, 12'd0, 5'd0));
        issue(make_item(OP_READ, $urandom, 13'd0, '0, 12'hFFF, 5'd31));
        issue(make_item(OP_READ, $urandom, 13'd0, '0, 12'd1023, 5'd31));
        issue(make_item(OP_READ, $urandom, 13'd0, '0, 12'd6, 5'd1));
        issue(make_item(OP_READ, $urandom, 13'd0, '0, 12'd5, 5'd0));
        issue(make_item(OP_UNDEFINED, '1, 13'h1FFF, '1, 12'hFFF, 5'd31));

        drain();
        write_filter(32'hA5A5_5A5A);
        issue(make_item(OP_ENTER, 32'h5A5A_A5A5, 13'd4, 64'd5, 12'd7, 5'd0));
        issue(make_item(OP_ENTER, 32'hA5A5_5A5A, 13'd4, 64'd5, 12'd7, 5'd0));
        // a foreign exit must leave the start in place
        issue(make_item(OP_EXIT, 32'h5A5A_A5A5, 13'd4, 64'd900, 12'd0, 5'd0));
        issue(make_item(OP_EXIT, 32'hA5A5_5A5A, 13'd4, 64'd3005, 12'd0, 5'd0));
        issue(make_item(OP_READ, 32'h5A5A_A5A5, 13'd0, '0, 12'd7, 5'd1));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_filter(phase_filter[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // hold off idling now and then for back-to-back transfers
                if (i % 50 == 0)
                    max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
                random_item();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[event_latency_histogram_monitor_unit.f]
design/elhm_pkg.sv
design/elhm_ram.sv
design/elhm_slot.sv
design/elhm_bucket.sv
design/event_latency_histogram_monitor_unit.sv
dv/latency_stats_checker.sv
dv/tb_top.sv
